FILE: rtl/utbs_pkg.sv
// package for the upper-triangular back-substitution core
// types, codes and sizing constants; no dependencies
`default_nettype none
package utbs_pkg;
  localparam int MAX_UNKNOWNS_DEF = 16;
  localparam int VALUE_BITS_DEF   = 32;
  localparam int FRAC_BITS        = 16;
  localparam int IDX_BITS         = 4;
  localparam int SIZE_BITS        = 5;
  localparam int ACC_BITS         = 192;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_COEF  = 2'd0,
    KIND_RHS   = 2'd1,
    KIND_SOLVE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW_RD, ST_ROW_WT, ST_ROW_INIT, ST_MAC_RD, ST_MAC_WT, ST_MAC_MUL,
    ST_MAC_ADD, ST_DIV, ST_DIV_FIN, ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic rd_row;     // read rhs and diagonal of row
    logic init_acc;   // acc = b << frac
    logic rd_mac;     // read coef and x at column
    logic do_mul;     // register the product
    logic do_add;     // accumulate product
    logic div_start;  // start divider
    logic div_step;   // one quotient bit
    logic div_fin;    // form result and write back
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/utbs_if.sv
// valid/ready channel interface with generic payload
// depends on nothing
`default_nettype none
interface utbs_chan_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/upper_triangular_back_substitution_core.sv
// top level of the upper-triangular back-substitution core
// depends on utbs_pkg, utbs_chan_if, utbs_ctrl, utbs_datapath
`default_nettype none
// Solves A x = b for upper-triangular A in signed Q16.16. Load beats (kind 0
// coefficient, kind 1 rhs) go into the stores. A solve beat runs rows n-1
// down to 0; row r has setup (row read, wait, accumulator init), then per
// off-diagonal term a memory read, wait, multiply and accumulate, then the
// bit-serial 192-bit divider and a step to form the result, then one result
// beat. The divider sets most of a solve's time. New input is taken only
// when no solve is in progress.
module upper_triangular_back_substitution_core
  import utbs_pkg::*;
#(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  utbs_chan_if.sink   in_ch,
  utbs_chan_if.sink   cfg,
  utbs_chan_if.source out_ch
);
  logic [SIZE_BITS-1:0] size_in_use;
  logic busy, start, res_valid, res_last, accept;
  cmd_t cmd;
  stat_t stat;
  logic [VALUE_BITS-1:0] res_value;
  logic res_zp, res_sat;
  logic [1:0] kind;
  logic [IDX_BITS-1:0] row_index, column_index;
  logic [VALUE_BITS-1:0] entry_value;
  logic in_range_r, in_range_c;

  assign kind = in_ch.data.kind;
  assign row_index = in_ch.data.row_index;
  assign column_index = in_ch.data.column_index;
  assign entry_value = in_ch.data.entry_value;

  // size register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) size_in_use <= SIZE_RESET;
    else if (cfg.valid) size_in_use <= cfg.data;
  end

  assign in_ch.ready = !busy;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_range_r = 32'(row_index) < MAX_UNKNOWNS;
  assign in_range_c = 32'(column_index) < MAX_UNKNOWNS;
  assign start = accept && (kind == KIND_SOLVE);

  utbs_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk, .rst, .start, .size_in_use, .busy, .stat, .cmd,
    .res_valid, .res_last, .res_ready(out_ch.ready)
  );

  utbs_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst,
    .coef_we(accept && kind == KIND_COEF && in_range_r && in_range_c
             && column_index >= row_index),
    .rhs_we(accept && kind == KIND_RHS && in_range_r),
    .wr_row(row_index), .wr_col(column_index), .wr_value(entry_value),
    .cmd, .stat, .res_value, .res_zero_pivot(res_zp), .res_saturated(res_sat)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.data.solution_index = cmd.row;
  assign out_ch.data.solution_value = res_value;
  assign out_ch.data.zero_pivot = res_zp;
  assign out_ch.data.saturated = res_sat;
  assign out_ch.data.last = res_last;

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ch.ready) else $error("input ready during solve");
  a_last_row0: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.last) |-> (out_ch.data.solution_index == '0))
    else $error("last not on row 0");
  a_zp_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(res_zp && res_sat)) else $error("zero pivot and saturated");
`endif
endmodule
`default_nettype wire

FILE: rtl/utbs_ctrl.sv
// controller state machine for the back-substitution core
// depends on utbs_pkg
`default_nettype none
module utbs_ctrl
  import utbs_pkg::*;
#(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SIZE_BITS-1:0] size_in_use,
  output logic                     busy,
  input  wire stat_t               stat,
  output cmd_t                     cmd,
  output logic                     res_valid,
  output logic                     res_last,
  input  wire logic                res_ready
);
  localparam int DIV_STEPS = ACC_BITS;
  localparam int DC_BITS   = $clog2(DIV_STEPS + 1);

  state_t state, state_next;
  logic [IDX_BITS-1:0] row, row_next, col, col_next, last_row, last_row_next;
  logic [DC_BITS-1:0]  dcnt, dcnt_next;
  logic [SIZE_BITS-1:0] n_eff;

  // clamp the size
  always_comb begin
    n_eff = size_in_use;
    if (size_in_use == '0) n_eff = SIZE_BITS'(1);
    if (32'(size_in_use) > MAX_UNKNOWNS) n_eff = SIZE_BITS'(MAX_UNKNOWNS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row <= '0;
      col <= '0;
      last_row <= '0;
      dcnt <= '0;
    end else begin
      state <= state_next;
      row <= row_next;
      col <= col_next;
      last_row <= last_row_next;
      dcnt <= dcnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    row_next = row;
    col_next = col;
    last_row_next = last_row;
    dcnt_next = dcnt;
    cmd = '0;
    cmd.row = row;
    cmd.col = col;
    res_valid = 1'b0;
    res_last = (row == '0);
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          row_next = IDX_BITS'(n_eff - 1'b1);
          last_row_next = IDX_BITS'(n_eff - 1'b1);
          state_next = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        cmd.rd_row = 1'b1;
        state_next = ST_ROW_WT;
      end
      // keep the diagonal address so the read data holds
      ST_ROW_WT: begin
        cmd.rd_row = 1'b1;
        state_next = ST_ROW_INIT;
      end
      ST_ROW_INIT: begin
        cmd.init_acc = 1'b1;
        col_next = row + 1'b1;
        state_next = (row == last_row) ? ST_DIV : ST_MAC_RD;
      end
      ST_MAC_RD: begin
        cmd.rd_mac = 1'b1;
        state_next = ST_MAC_WT;
      end
      ST_MAC_WT: state_next = ST_MAC_MUL;
      ST_MAC_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = ST_MAC_ADD;
      end
      ST_MAC_ADD: begin
        cmd.do_add = 1'b1;
        col_next = col + 1'b1;
        state_next = (col == last_row) ? ST_DIV : ST_MAC_RD;
      end
      ST_DIV: begin
        if (dcnt == '0) begin
          cmd.div_start = 1'b1;
          dcnt_next = DC_BITS'(DIV_STEPS);
        end else begin
          cmd.div_step = 1'b1;
          dcnt_next = dcnt - 1'b1;
          if (stat.div_done) state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (row == '0) state_next = ST_IDLE;
          else begin
            row_next = row - 1'b1;
            state_next = ST_ROW_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/utbs_datapath.sv
// datapath: stores, multiplier, wide accumulator, restoring divider
// depends on utbs_pkg
`default_nettype none
module utbs_datapath
  import utbs_pkg::*;
#(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
  parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  coef_we,
  input  wire logic                  rhs_we,
  input  wire logic [IDX_BITS-1:0]   wr_row,
  input  wire logic [IDX_BITS-1:0]   wr_col,
  input  wire logic [VALUE_BITS-1:0] wr_value,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  output logic [VALUE_BITS-1:0]      res_value,
  output logic                       res_zero_pivot,
  output logic                       res_saturated
);
  localparam int IW = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int PW = 2 * VALUE_BITS;
  localparam int QB = PW;   // quotient bits kept before overflow

  logic [VALUE_BITS-1:0] coef_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
  logic [VALUE_BITS-1:0] x_mem [MAX_UNKNOWNS];
  logic [VALUE_BITS-1:0] coef_rd, x_rd, diag;
  logic [2*IW-1:0] wr_addr, rd_addr;
  logic [IW-1:0] x_addr;

  logic [ACC_BITS-1:0] acc, rem_sh;
  logic [PW-1:0] prod;
  logic prod_neg;
  logic [VALUE_BITS-1:0] a_mag, x_mag, b_mag;
  logic [VALUE_BITS:0] dmag;
  logic [PW:0] rem;
  logic [PW:0] rem_try;
  logic [QB-1:0] q;
  logic over, res_neg;
  logic [7:0] bit_cnt;
  logic [QB-1:0] lim;
  logic sat_c, zp_c;
  logic [VALUE_BITS-1:0] val_c;

  function automatic logic [VALUE_BITS-1:0] mag(input logic [VALUE_BITS-1:0] v);
    return v[VALUE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  assign wr_addr = {IW'(wr_row), IW'(wr_col)};
  assign rd_addr = cmd.rd_row ? {IW'(cmd.row), IW'(cmd.row)} : {IW'(cmd.row), IW'(cmd.col)};
  assign x_addr  = cmd.rd_row ? IW'(cmd.row) : IW'(cmd.col);

  // coefficient memory, registered read
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[wr_addr] <= wr_value;
    coef_rd <= coef_mem[rd_addr];
  end

  // rhs and solution memory; solved values write back over rhs
  always_ff @(posedge clk) begin
    if (rhs_we) x_mem[IW'(wr_row)] <= wr_value;
    else if (cmd.div_fin) x_mem[IW'(cmd.row)] <= val_c;
    x_rd <= x_mem[x_addr];
  end

  assign a_mag = mag(coef_rd);
  assign x_mag = mag(x_rd);
  assign b_mag = mag(x_rd);

  // multiply, accumulate
  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      prod <= PW'(a_mag) * PW'(x_mag);
      prod_neg <= (coef_rd[VALUE_BITS-1] == x_rd[VALUE_BITS-1]);
    end
    if (cmd.init_acc) begin
      diag <= coef_rd;
      acc <= x_rd[VALUE_BITS-1] ? ~(ACC_BITS'(b_mag) << FRAC_BITS) + 1'b1
                                : ACC_BITS'(b_mag) << FRAC_BITS;
    end else if (cmd.do_add) begin
      acc <= prod_neg ? acc - ACC_BITS'(prod) : acc + ACC_BITS'(prod);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_try = {rem[PW-1:0], rem_sh[ACC_BITS-1]};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_sh <= acc[ACC_BITS-1] ? ~acc + 1'b1 : acc;
      res_neg <= acc[ACC_BITS-1] ^ diag[VALUE_BITS-1];
      dmag <= {1'b0, mag(diag)};
      rem <= '0;
      q <= '0;
      over <= 1'b0;
      bit_cnt <= 8'(ACC_BITS - 1);
    end else if (cmd.div_step) begin
      rem_sh <= rem_sh << 1;
      bit_cnt <= bit_cnt - 1'b1;
      if (rem_try >= PW'(dmag)) begin
        rem <= rem_try - (PW+1)'(dmag);
        if (32'(bit_cnt) >= QB) over <= 1'b1;
        q <= {q[QB-2:0], 1'b1};
      end else begin
        rem <= rem_try;
        q <= {q[QB-2:0], 1'b0};
      end
    end
  end

  // saturate and sign the quotient
  always_comb begin
    lim = QB'(1) << (VALUE_BITS - 1);
    if (!res_neg) lim = lim - 1'b1;
    zp_c = (diag == '0);
    sat_c = !zp_c && (over || q > lim);
    if (zp_c) val_c = '0;
    else if (sat_c) val_c = res_neg ? VALUE_BITS'(~lim + 1'b1) : VALUE_BITS'(lim);
    else val_c = res_neg ? VALUE_BITS'(~q + 1'b1) : VALUE_BITS'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_fin) begin
      res_value <= val_c;
      res_zero_pivot <= zp_c;
      res_saturated <= sat_c;
    end
  end

  // high during the step that produces quotient bit 0
  assign stat.div_done = (bit_cnt == '0) && !rst;
endmodule
`default_nettype wire

FILE: bench/utbs_tb_pkg.sv
`timescale 1ns / 100ps
// beat layouts of the back-substitution core channels, as seen by the bench
// depends on utbs_pkg
package utbs_tb_pkg;
  import utbs_pkg::*;

  typedef struct packed {
    kind_t                      kind;
    logic [IDX_BITS-1:0]        row_index;
    logic [IDX_BITS-1:0]        column_index;
    logic signed [VALUE_BITS_DEF-1:0] entry_value;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]        solution_index;
    logic signed [VALUE_BITS_DEF-1:0] solution_value;
    logic                       zero_pivot;
    logic                       saturated;
    logic                       last;
  } out_beat_t;

  typedef logic [SIZE_BITS-1:0] size_word_t;
endpackage

FILE: bench/utbs_checker.sv
`timescale 1ns / 100ps
// watches the load, config and result channels, predicts each solve in fixed
// point and compares the results; depends on utbs_pkg and utbs_tb_pkg
module utbs_checker
  import utbs_pkg::*;
  import utbs_tb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  in_beat_t       in_data,
  input  wire logic      cfg_valid,
  input  wire logic      cfg_ready,
  input  size_word_t     cfg_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  out_beat_t      out_data,
  output int             errors,
  output int             pending,
  output int             solutions_seen
);
  localparam int N = MAX_UNKNOWNS_DEF;

  logic signed [31:0] coef_mem [N][N];
  logic signed [31:0] x_mem [N];
  size_word_t         size_reg;
  out_beat_t          solution_q [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // back substitution over the rows in use, last row first
  task automatic solve_system();
    int n;
    logic signed [191:0] acc;
    logic signed [63:0]  prod;
    logic [191:0]        acc_mag, div_mag, quo, lim;
    logic signed [31:0]  d;
    logic                neg;
    out_beat_t           r;
    n = (size_reg == 0) ? 1 : (size_reg > N) ? N : int'(size_reg);
    for (int row = n - 1; row >= 0; row--) begin
      acc = 192'(x_mem[row]) <<< FRAC_BITS;
      for (int col = row + 1; col < n; col++) begin
        prod = 64'(coef_mem[row][col]) * 64'(x_mem[col]);
        acc  = acc - 192'(prod);
      end
      d = coef_mem[row][row];
      r = '0;
      r.solution_index = IDX_BITS'(row);
      r.last = (row == 0);
      if (d == 0) begin
        r.zero_pivot = 1'b1;
      end else begin
        acc_mag = acc[191] ? -acc : acc;
        div_mag = d[31] ? 192'(-64'(d)) : 192'(d);
        quo = acc_mag / div_mag;
        neg = acc[191] ^ d[31];
        lim = neg ? 192'h8000_0000 : 192'h7fff_ffff;
        if (quo > lim) begin
          quo = lim;
          r.saturated = 1'b1;
        end
        r.solution_value = neg ? -quo[31:0] : quo[31:0];
      end
      x_mem[row] = r.solution_value;
      solution_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst) begin
      size_reg = SIZE_RESET;
      for (int i = 0; i < N; i++) begin
        x_mem[i] = '0;
        for (int j = 0; j < N; j++) coef_mem[i][j] = '0;
      end
    end else begin
      // result beats against the oldest expectation
      if (out_valid && out_ready) begin
        solutions_seen++;
        if (solution_q.size() == 0) begin
          report($sformatf("unexpected result index %0d", out_data.solution_index));
        end else begin
          exp_beat = solution_q.pop_front();
          if (out_data.solution_index !== exp_beat.solution_index)
            report($sformatf("index %0d, want %0d", out_data.solution_index,
                             exp_beat.solution_index));
          if (out_data.solution_value !== exp_beat.solution_value)
            report($sformatf("row %0d value %h, want %h", exp_beat.solution_index,
                             out_data.solution_value, exp_beat.solution_value));
          if (out_data.zero_pivot !== exp_beat.zero_pivot)
            report($sformatf("row %0d zero_pivot %b", exp_beat.solution_index,
                             out_data.zero_pivot));
          if (out_data.saturated !== exp_beat.saturated)
            report($sformatf("row %0d saturated %b", exp_beat.solution_index,
                             out_data.saturated));
          if (out_data.last !== exp_beat.last)
            report($sformatf("row %0d last %b", exp_beat.solution_index, out_data.last));
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      // load and solve beats
      if (in_valid && in_ready) begin
        case (in_data.kind)
          KIND_COEF: begin
            if (in_data.column_index >= in_data.row_index)
              coef_mem[in_data.row_index][in_data.column_index] = in_data.entry_value;
          end
          KIND_RHS:   x_mem[in_data.row_index] = in_data.entry_value;
          KIND_SOLVE: solve_system();
          default: ;
        endcase
      end
    end
    pending = solution_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    solutions_seen = 0;
  end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// stimulus, flow control and verdict for the back-substitution core
// depends on utbs_pkg, utbs_chan_if, utbs_tb_pkg, utbs_checker and the core
module tb_top;
  import utbs_pkg::*;
  import utbs_tb_pkg::*;

  localparam int N = MAX_UNKNOWNS_DEF;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;

  utbs_chan_if #(.payload_t(in_beat_t))   in_ch (clk);
  utbs_chan_if #(.payload_t(size_word_t)) cfg (clk);
  utbs_chan_if #(.payload_t(out_beat_t))  out_ch (clk);

  upper_triangular_back_substitution_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .out_ch (out_ch)
  );

  int errors, pending, solutions_seen;

  utbs_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .errors(errors), .pending(pending), .solutions_seen(solutions_seen)
  );

  int  send_pct, recv_pct;
  int  hold_token, hold_len;
  int  beats_sent, solves_sent;
  bit  coef_ok [N][N];
  bit  rhs_ok [N];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus long hold-offs on request
  int hold_seen, hold_cnt;
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_cnt  = hold_len;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // watchdog on cycles with no beat anywhere
  int quiet;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (cfg.valid && cfg.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ready is checked mid-cycle, so the beat lands at the following rising edge
  task automatic send_beat(input kind_t k, input int r, input int c,
                           input logic [31:0] v);
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{k, IDX_BITS'(r), IDX_BITS'(c), v};
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    if (k == KIND_COEF && c >= r) coef_ok[r][c] = 1'b1;
    if (k == KIND_RHS) rhs_ok[r] = 1'b1;
    if (k == KIND_SOLVE) solves_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input int value);
    wait_drained();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= SIZE_BITS'(value);
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // mix of extremes, modest Q16.16 values and raw bit patterns
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom();
      default: return 32'($signed($urandom_range(8)) - 4) * 32'h1_0000
                      + 32'($urandom_range(16'hffff));
    endcase
  endfunction

  function automatic logic [31:0] pick_diag();
    logic [31:0] v;
    v = pick_value();
    return (v == 0) ? 32'h0001_0000 : v;
  endfunction

  // load whatever the next solve of n rows would read but was never written
  task automatic fill_missing(input int n);
    for (int r = 0; r < n; r++) begin
      if (!rhs_ok[r]) send_beat(KIND_RHS, r, $urandom_range(15), pick_value());
      for (int c = r; c < n; c++)
        if (!coef_ok[r][c])
          send_beat(KIND_COEF, r, c, (r == c) ? pick_diag() : pick_value());
    end
  endtask

  function automatic int rows_of(input int size);
    return (size == 0) ? 1 : (size > N) ? N : size;
  endfunction

  task automatic noise_beats(input int count, input int n);
    int r, c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(n - 1);
      c = $urandom_range(15);
      case ($urandom_range(9))
        0: send_beat(KIND_NONE, $urandom_range(15), c, $urandom());
        1, 2, 3: send_beat(KIND_RHS, r, c, pick_value());
        default: begin
          if (c < r && $urandom_range(1)) c = $urandom_range(r, n - 1);
          send_beat(KIND_COEF, r, c, (r == c) ? pick_diag() : pick_value());
        end
      endcase
    end
  endtask

  int size_now, phase;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg.valid   = 1'b0;
    cfg.data    = '0;
    out_ch.ready = 1'b0;
    send_pct = 0;
    recv_pct = 0;
    hold_token = 0;
    hold_len = 0;
    hold_seen = 0;
    hold_cnt = 0;
    quiet = 0;
    beats_sent = 0;
    solves_sent = 0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: two rows at the value extremes
    write_size(2);
    send_beat(KIND_COEF, 0, 0, 32'h7fff_ffff);
    send_beat(KIND_COEF, 0, 1, 32'h8000_0000);
    send_beat(KIND_COEF, 1, 1, 32'h0001_0000);
    send_beat(KIND_COEF, 1, 0, 32'h1234_5678);   // below the diagonal, dropped
    send_beat(KIND_RHS, 0, 0, 32'h7fff_ffff);
    send_beat(KIND_RHS, 1, 0, 32'h8000_0000);
    send_beat(KIND_NONE, 15, 15, 32'hffff_ffff);
    send_beat(KIND_SOLVE, 0, 0, '0);
    // repeated solve from stored solutions, then a zero pivot feeding row 0
    send_beat(KIND_SOLVE, 0, 0, '0);
    send_beat(KIND_COEF, 1, 1, '0);
    send_beat(KIND_SOLVE, 0, 0, '0);
    // tiny diagonal forces clipping
    send_beat(KIND_COEF, 1, 1, 32'h0000_0001);
    send_beat(KIND_RHS, 1, 0, 32'h0100_0000);
    send_beat(KIND_SOLVE, 0, 0, '0);
    // size zero acts as one row
    write_size(0);
    send_beat(KIND_COEF, 0, 0, 32'hffff_0000);
    send_beat(KIND_SOLVE, 0, 0, '0);

    // random phases, idling pattern rotating with the phase
    phase = 0;
    while (beats_sent < 160 || phase < 8) begin
      case (phase % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 51; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 51; end
        default: begin send_pct = 26; recv_pct = 26; end
      endcase
      if (phase == 3) size_now = 31;
      else if (phase == 5) size_now = 16;
      else if (phase == 6) size_now = 1;
      else size_now = $urandom_range(1, 5);
      write_size(size_now);
      noise_beats($urandom_range(2, 5), rows_of(size_now));
      fill_missing(rows_of(size_now));
      if (phase == 2) begin
        // hold results back while loads keep coming behind the solve
        hold_len = 400;
        hold_token++;
        send_beat(KIND_SOLVE, 0, 0, '0);
        noise_beats(3, rows_of(size_now));
        fill_missing(rows_of(size_now));
      end
      send_beat(KIND_SOLVE, $urandom_range(15), $urandom_range(15), $urandom());
      if ($urandom_range(3) == 0) send_beat(KIND_SOLVE, 0, 0, '0);
      phase++;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d input beats, %0d solves, %0d solution beats over %0d phases",
             beats_sent, solves_sent, solutions_seen, phase);
    $display("sizes 0, 1, small, 16 and 31; zero pivots, clipping, ignored loads");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/utbs_pkg.sv
rtl/utbs_if.sv
rtl/utbs_ctrl.sv
rtl/utbs_datapath.sv
rtl/upper_triangular_back_substitution_core.sv
bench/utbs_tb_pkg.sv
bench/utbs_checker.sv
bench/tb_top.sv
